/* rtl/assert_macros.svh */
// Assertion helper macros shared by the parser RTL.
// Included by every module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define TLSHP_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next clock cycle.
`define TLSHP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/tlshp_pkg.sv */
// Types, codes and lookup functions of the TLS hello stream parser.
// No dependencies; used by every parser module.
package tlshp_pkg;

   // Parse phases
   typedef enum logic [4:0] {
      PH_IDLE, PH_DONE, PH_HDR, PH_HSTYPE, PH_CVER_HI, PH_CVER_LO, PH_CSID,
      PH_CSLEN_HI, PH_CSLEN_LO, PH_SUITE_HI, PH_SUITE_LO, PH_COMPLEN,
      PH_EXTL_HI, PH_EXTL_LO, PH_ET_HI, PH_ET_LO, PH_ES_HI, PH_ES_LO,
      PH_EXT_SKIP, PH_SL_HI, PH_SL_LO, PH_NTYPE, PH_NL_HI, PH_NL_LO, PH_NAME,
      PH_SVER_HI, PH_SVER_LO, PH_SSID, PH_SCS_HI, PH_SCS_LO, PH_SCOMP, PH_SKIP
   } phase_type;

   // Result kinds
   typedef enum logic [3:0] {
      EV_REC_HEADER, EV_REC_VERSION, EV_CLIENT_VERSION, EV_OFFERED_SUITE,
      EV_EXTENSION, EV_SNI_BYTE, EV_SERVER_VERSION, EV_SELECTED_SUITE,
      EV_COMPRESSION, EV_OTHER_HS, EV_ERROR, EV_HELLO_DONE
   } event_kind_type;

   // Error codes
   typedef enum logic [2:0] {
      ERR_NONE, ERR_PAYLOAD_SHORT, ERR_NOT_HANDSHAKE, ERR_INCOMPLETE,
      ERR_HS_SHORT, ERR_SERVER_SHORT
   } error_code_type;

   // Counter slots
   localparam logic [1:0] CNT_CLIENT       = 2'd0;
   localparam logic [1:0] CNT_SERVER       = 2'd1;
   localparam logic [1:0] CNT_WEAK_CIPHER  = 2'd2;
   localparam logic [1:0] CNT_WEAK_VERSION = 2'd3;

   localparam logic [7:0] REC_HANDSHAKE = 8'd22;
   localparam logic [7:0] HS_CLIENT     = 8'd1;
   localparam logic [7:0] HS_SERVER     = 8'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // One result entry as it travels from front to back
   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    value;
      logic [15:0]    len;
      logic [7:0]     rtype;
      logic           weak_flag;
      logic [4:0]     code;
      error_code_type err;
      logic           bump_en;
      logic [1:0]     bump_idx;
      logic           last;
   } event_type;

   function automatic event_type mk_event(event_kind_type kind, logic [15:0] val,
                                          logic [15:0] len, logic [7:0] rtype,
                                          logic weak_flag, logic [4:0] code,
                                          error_code_type err, logic bump_en,
                                          logic [1:0] bump_idx);
      event_type e;
      e.kind      = kind;
      e.value     = val;
      e.len       = len;
      e.rtype     = rtype;
      e.weak_flag = weak_flag;
      e.code      = code;
      e.err       = err;
      e.bump_en   = bump_en;
      e.bump_idx  = bump_idx;
      e.last      = 1'b0;
      return e;
   endfunction

   function automatic logic [4:0] ver_code(logic [15:0] v);
      logic [15:0] d;
      d = v - 16'h0300;
      if (v >= 16'h0300 && v <= 16'h0304) return 5'(d + 16'd1);
      return 5'd0;
   endfunction

   function automatic logic ver_weak(logic [15:0] v);
      return (v >= 16'h0300 && v <= 16'h0302);
   endfunction

   function automatic logic suite_weak(logic [15:0] s);
      return (s <= 16'h0005 || s == 16'h000A);
   endfunction

   // Dense index of known cipher suites, zero for unknown
   function automatic logic [4:0] suite_code(logic [15:0] s);
      case (s)
         16'h1301: return 5'd1;
         16'h1302: return 5'd2;
         16'h1303: return 5'd3;
         16'h1304: return 5'd4;
         16'h1305: return 5'd5;
         16'h009C: return 5'd6;
         16'h009D: return 5'd7;
         16'h002F: return 5'd8;
         16'h0035: return 5'd9;
         16'h003C: return 5'd10;
         16'h003D: return 5'd11;
         16'hC02B: return 5'd12;
         16'hC02C: return 5'd13;
         16'hC02F: return 5'd14;
         16'hC030: return 5'd15;
         16'hC00A: return 5'd16;
         16'hC009: return 5'd17;
         16'hC013: return 5'd18;
         16'hC014: return 5'd19;
         16'hCCA8: return 5'd20;
         16'hCCA9: return 5'd21;
         16'h0000: return 5'd22;
         16'h0001: return 5'd23;
         16'h0002: return 5'd24;
         16'h0003: return 5'd25;
         16'h0004: return 5'd26;
         16'h0005: return 5'd27;
         16'h000A: return 5'd28;
         default:  return 5'd0;
      endcase
   endfunction

endpackage

/* rtl/tlshp_front.sv */
// Front end: accepts payload beats, walks the record/hello layout and
// produces up to two result entries per beat. Depends on tlshp_pkg.
`include "assert_macros.svh"

module tlshp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 first_byte,
   input  logic [15:0]          payload_length,
   input  logic                 csr_we,
   input  logic [7:0]           csr_wdata,
   output logic [1:0]           push_n,
   output tlshp_pkg::event_type ev0,
   output tlshp_pkg::event_type ev1
);

   tlshp_pkg::phase_type phase_ff, phase_in, skip_ph_ff, skip_ph_in;
   logic [15:0] pos_ff, pos_in, tot_ff, tot_in, rl_ff, rl_in, rv_ff, rv_in;
   logic [7:0]  rt_ff, rt_in, acc_ff, acc_in, max_ff, ns_ff, ns_in;
   logic [16:0] sec_ff, sec_in, ext_ff, ext_in, skip_ff, skip_in;
   logic [14:0] sl_ff, sl_in;
   logic [15:0] ek_ff, ek_in, nf_ff, nf_in, nr_ff, nr_in;
   logic        hf_ff, hf_in;
   tlshp_pkg::event_type ev [2];
   logic [1:0]  n;

   // Parse one beat
   always_comb begin
      tlshp_pkg::phase_type ph;
      tlshp_pkg::event_type e;
      logic [15:0] pos, tot, rl, rv, v;
      logic [7:0]  rt, b;
      logic [17:0] nx, lim, nxb, nxv, g_tgt, es_dend;
      logic        w, active, f_goto, f_sni, f_eskip, f_next, f_done;
      tlshp_pkg::phase_type g_ph;

      b   = data_byte;
      ph  = first_byte ? tlshp_pkg::PH_HDR : phase_ff;
      pos = first_byte ? 16'd0 : pos_ff;
      tot = first_byte ? payload_length : tot_ff;
      rl  = first_byte ? 16'd0 : rl_ff;
      rv  = first_byte ? 16'd0 : rv_ff;
      rt  = first_byte ? 8'd0 : rt_ff;
      v   = {acc_ff, b};
      nx  = {2'b0, pos} + 18'd1;
      lim = {2'b0, rl} + 18'd5;
      nxb = nx + {10'b0, b};
      nxv = nx + {2'b0, v};
      w   = 1'b0;
      e   = '0;
      g_tgt = '0;
      g_ph  = tlshp_pkg::PH_DONE;
      es_dend = '0;
      f_goto = 1'b0; f_sni = 1'b0; f_eskip = 1'b0; f_next = 1'b0; f_done = 1'b0;
      ev[0] = '0;
      ev[1] = '0;
      n = 2'd0;

      phase_in = phase_ff; pos_in = pos_ff; tot_in = tot_ff; rl_in = rl_ff;
      rv_in = rv_ff; rt_in = rt_ff; acc_in = acc_ff; sec_in = sec_ff;
      ext_in = ext_ff; skip_in = skip_ff; skip_ph_in = skip_ph_ff; sl_in = sl_ff;
      ek_in = ek_ff; hf_in = hf_ff; nf_in = nf_ff; nr_in = nr_ff; ns_in = ns_ff;
      active = 1'b0;

      if (accept) begin
         phase_in = ph; pos_in = pos; tot_in = tot; rl_in = rl; rv_in = rv; rt_in = rt;
         if (first_byte && payload_length < 16'd5) begin
            ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_ERROR, 16'd0, 16'd0, 8'd0, 1'b0,
                                        5'd0, tlshp_pkg::ERR_PAYLOAD_SHORT, 1'b0, 2'd0);
            n = 2'd1;
            phase_in = tlshp_pkg::PH_DONE;
         end else if (ph != tlshp_pkg::PH_IDLE && ph != tlshp_pkg::PH_DONE) begin
            if (pos >= tot) phase_in = tlshp_pkg::PH_DONE;
            else active = 1'b1;
         end
      end

      if (active) begin
         pos_in = (pos == 16'hFFFF) ? pos : pos + 16'd1;
         case (ph)
            tlshp_pkg::PH_HDR: begin
               if (pos == 16'd0) rt_in = b;
               else if (pos == 16'd1 || pos == 16'd3) acc_in = b;
               else if (pos == 16'd2) rv_in = v;
               else begin
                  rl_in = v;
                  ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_REC_HEADER, rv, v, rt, 1'b0,
                                              tlshp_pkg::ver_code(rv),
                                              tlshp_pkg::ERR_NONE, 1'b0, 2'd0);
                  n = 2'd1;
                  if (rt != tlshp_pkg::REC_HANDSHAKE) begin
                     ev[1] = tlshp_pkg::mk_event(tlshp_pkg::EV_ERROR, 16'd0, 16'd0, rt,
                                                 1'b0, 5'd0, tlshp_pkg::ERR_NOT_HANDSHAKE,
                                                 1'b0, 2'd0);
                     n = 2'd2;
                     phase_in = tlshp_pkg::PH_DONE;
                  end else if (tot < 16'd9) phase_in = tlshp_pkg::PH_DONE;
                  else phase_in = tlshp_pkg::PH_HSTYPE;
               end
            end
            tlshp_pkg::PH_HSTYPE: begin
               if (b == tlshp_pkg::HS_CLIENT) begin
                  if (lim > {2'b0, tot}) begin
                     ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_ERROR, 16'd0, 16'd0, rt,
                                                 1'b0, 5'd0, tlshp_pkg::ERR_INCOMPLETE,
                                                 1'b0, 2'd0);
                     n = 2'd1;
                     phase_in = tlshp_pkg::PH_DONE;
                  end else if (rl < 16'd4) begin
                     ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_ERROR, 16'd0, 16'd0, rt,
                                                 1'b0, 5'd0, tlshp_pkg::ERR_HS_SHORT,
                                                 1'b0, 2'd0);
                     n = 2'd1;
                     phase_in = tlshp_pkg::PH_DONE;
                  end else begin
                     w = tlshp_pkg::ver_weak(rv);
                     ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_REC_VERSION, rv, rl, rt, w,
                                                 tlshp_pkg::ver_code(rv),
                                                 tlshp_pkg::ERR_NONE, w,
                                                 tlshp_pkg::CNT_WEAK_VERSION);
                     n = 2'd1;
                     if (rl < 16'd6) phase_in = tlshp_pkg::PH_DONE;
                     else begin
                        f_goto = 1'b1; g_tgt = 18'd9; g_ph = tlshp_pkg::PH_CVER_HI;
                     end
                  end
               end else if (b == tlshp_pkg::HS_SERVER) begin
                  if (tot < 16'd47) begin
                     ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_ERROR, 16'd0, 16'd0, rt,
                                                 1'b0, 5'd0, tlshp_pkg::ERR_SERVER_SHORT,
                                                 1'b0, 2'd0);
                     n = 2'd1;
                     phase_in = tlshp_pkg::PH_DONE;
                  end else begin
                     f_goto = 1'b1; g_tgt = 18'd9; g_ph = tlshp_pkg::PH_SVER_HI;
                  end
               end else begin
                  ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_OTHER_HS, {8'd0, b}, 16'd0,
                                              rt, 1'b0, 5'd0, tlshp_pkg::ERR_NONE,
                                              1'b0, 2'd0);
                  n = 2'd1;
                  phase_in = tlshp_pkg::PH_DONE;
               end
            end
            tlshp_pkg::PH_CVER_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_CVER_LO;
            end
            tlshp_pkg::PH_CSLEN_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_CSLEN_LO;
            end
            tlshp_pkg::PH_SUITE_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_SUITE_LO;
            end
            tlshp_pkg::PH_EXTL_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_EXTL_LO;
            end
            tlshp_pkg::PH_ET_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_ET_LO;
            end
            tlshp_pkg::PH_ES_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_ES_LO;
            end
            tlshp_pkg::PH_SL_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_SL_LO;
            end
            tlshp_pkg::PH_NL_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_NL_LO;
            end
            tlshp_pkg::PH_SVER_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_SVER_LO;
            end
            tlshp_pkg::PH_SCS_HI: begin
               acc_in = b; phase_in = tlshp_pkg::PH_SCS_LO;
            end
            tlshp_pkg::PH_CVER_LO: begin
               ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_CLIENT_VERSION, v, 16'd0, rt,
                                           1'b0, tlshp_pkg::ver_code(v),
                                           tlshp_pkg::ERR_NONE, 1'b1,
                                           tlshp_pkg::CNT_CLIENT);
               n = 2'd1;
               if (rl < 16'd39) phase_in = tlshp_pkg::PH_DONE;
               else begin
                  f_goto = 1'b1; g_tgt = 18'd43; g_ph = tlshp_pkg::PH_CSID;
               end
            end
            tlshp_pkg::PH_CSID, tlshp_pkg::PH_COMPLEN: begin
               if (nxb + 18'd2 > lim) phase_in = tlshp_pkg::PH_DONE;
               else begin
                  f_goto = 1'b1; g_tgt = nxb;
                  g_ph = (ph == tlshp_pkg::PH_CSID) ? tlshp_pkg::PH_CSLEN_HI
                                                   : tlshp_pkg::PH_EXTL_HI;
               end
            end
            tlshp_pkg::PH_CSLEN_LO: begin
               if (nxv > lim) phase_in = tlshp_pkg::PH_DONE;
               else begin
                  sec_in = nxv[16:0];
                  sl_in  = v[15:1];
                  if (v[15:1] == 15'd0) begin
                     if (nxv + 18'd1 > lim) phase_in = tlshp_pkg::PH_DONE;
                     else begin
                        f_goto = 1'b1; g_tgt = nxv; g_ph = tlshp_pkg::PH_COMPLEN;
                     end
                  end else phase_in = tlshp_pkg::PH_SUITE_HI;
               end
            end
            tlshp_pkg::PH_SUITE_LO: begin
               w = tlshp_pkg::suite_weak(v);
               ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_OFFERED_SUITE, v, 16'd0, rt, w,
                                           tlshp_pkg::suite_code(v), tlshp_pkg::ERR_NONE,
                                           w, tlshp_pkg::CNT_WEAK_CIPHER);
               n = 2'd1;
               sl_in = sl_ff - 15'd1;
               if (sl_ff == 15'd1) begin
                  if ({1'b0, sec_ff} + 18'd1 > lim) phase_in = tlshp_pkg::PH_DONE;
                  else begin
                     f_goto = 1'b1; g_tgt = {1'b0, sec_ff}; g_ph = tlshp_pkg::PH_COMPLEN;
                  end
               end else phase_in = tlshp_pkg::PH_SUITE_HI;
            end
            tlshp_pkg::PH_EXTL_LO: begin
               if (nxv > lim) phase_in = tlshp_pkg::PH_DONE;
               else begin
                  ext_in = nxv[16:0];
                  f_next = 1'b1;
               end
            end
            tlshp_pkg::PH_ET_LO: begin
               ek_in = v; phase_in = tlshp_pkg::PH_ES_HI;
            end
            tlshp_pkg::PH_ES_LO: begin
               if (nxv > {1'b0, ext_ff}) f_done = 1'b1;
               else if (ek_ff != 16'd0) begin
                  ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_EXTENSION, ek_ff, v, rt, 1'b0,
                                              5'd0, tlshp_pkg::ERR_NONE, 1'b0, 2'd0);
                  n = 2'd1;
                  f_eskip = 1'b1; es_dend = nxv;
               end else if (nx + 18'd2 > {1'b0, ext_ff}) f_done = 1'b1;
               else if (v < 16'd2) begin
                  f_eskip = 1'b1; es_dend = nxv;
               end else begin
                  sec_in = nxv[16:0];
                  phase_in = tlshp_pkg::PH_SL_HI;
               end
            end
            tlshp_pkg::PH_EXT_SKIP: begin
               if (nx >= {1'b0, sec_ff}) f_next = 1'b1;
            end
            tlshp_pkg::PH_SL_LO: f_sni = 1'b1;
            tlshp_pkg::PH_NTYPE: begin
               hf_in = (b == 8'd0);
               phase_in = tlshp_pkg::PH_NL_HI;
            end
            tlshp_pkg::PH_NL_LO: begin
               if (nxv > {1'b0, sec_ff}) begin
                  f_eskip = 1'b1; es_dend = {1'b0, sec_ff};
               end else begin
                  nf_in = v; nr_in = v; ns_in = 8'd0;
                  if (v == 16'd0) f_sni = 1'b1;
                  else phase_in = tlshp_pkg::PH_NAME;
               end
            end
            tlshp_pkg::PH_NAME: begin
               if (hf_ff && ns_ff < max_ff) begin
                  ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_SNI_BYTE, {8'd0, b}, nf_ff, rt,
                                              1'b0, 5'd0, tlshp_pkg::ERR_NONE, 1'b0, 2'd0);
                  n = 2'd1;
                  ns_in = ns_ff + 8'd1;
               end
               nr_in = nr_ff - 16'd1;
               if (nr_ff == 16'd1) f_sni = 1'b1;
            end
            tlshp_pkg::PH_SVER_LO: begin
               w = tlshp_pkg::ver_weak(v);
               ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_SERVER_VERSION, v, 16'd0, rt, w,
                                           tlshp_pkg::ver_code(v), tlshp_pkg::ERR_NONE,
                                           w, tlshp_pkg::CNT_WEAK_VERSION);
               n = 2'd1;
               f_goto = 1'b1; g_tgt = 18'd43; g_ph = tlshp_pkg::PH_SSID;
            end
            tlshp_pkg::PH_SSID: begin
               if (nxb + 18'd2 <= {2'b0, tot}) begin
                  f_goto = 1'b1; g_tgt = nxb; g_ph = tlshp_pkg::PH_SCS_HI;
               end else if (nxb + 18'd1 <= {2'b0, tot}) begin
                  f_goto = 1'b1; g_tgt = nxb; g_ph = tlshp_pkg::PH_SCOMP;
               end else begin
                  ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_HELLO_DONE, 16'd0, 16'd0, rt,
                                              1'b0, 5'd0, tlshp_pkg::ERR_NONE, 1'b1,
                                              tlshp_pkg::CNT_SERVER);
                  n = 2'd1;
                  phase_in = tlshp_pkg::PH_DONE;
               end
            end
            tlshp_pkg::PH_SCS_LO: begin
               w = tlshp_pkg::suite_weak(v);
               ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_SELECTED_SUITE, v, 16'd0, rt, w,
                                           tlshp_pkg::suite_code(v), tlshp_pkg::ERR_NONE,
                                           w, tlshp_pkg::CNT_WEAK_CIPHER);
               n = 2'd1;
               if (nx + 18'd1 <= {2'b0, tot}) phase_in = tlshp_pkg::PH_SCOMP;
               else begin
                  ev[1] = tlshp_pkg::mk_event(tlshp_pkg::EV_HELLO_DONE, 16'd0, 16'd0, rt,
                                              1'b0, 5'd0, tlshp_pkg::ERR_NONE, 1'b1,
                                              tlshp_pkg::CNT_SERVER);
                  n = 2'd2;
                  phase_in = tlshp_pkg::PH_DONE;
               end
            end
            tlshp_pkg::PH_SCOMP: begin
               ev[0] = tlshp_pkg::mk_event(tlshp_pkg::EV_COMPRESSION, {8'd0, b}, 16'd0, rt,
                                           1'b0, 5'd0, tlshp_pkg::ERR_NONE, 1'b0, 2'd0);
               ev[1] = tlshp_pkg::mk_event(tlshp_pkg::EV_HELLO_DONE, 16'd0, 16'd0, rt,
                                           1'b0, 5'd0, tlshp_pkg::ERR_NONE, 1'b1,
                                           tlshp_pkg::CNT_SERVER);
               n = 2'd2;
               phase_in = tlshp_pkg::PH_DONE;
            end
            tlshp_pkg::PH_SKIP: begin
               if (nx >= {1'b0, skip_ff}) phase_in = skip_ph_ff;
            end
            default: phase_in = tlshp_pkg::PH_DONE;
         endcase

         // Resolve jumps: skip ahead, next name, skip extension, next extension, finish
         if (f_goto) begin
            if (g_tgt <= nx) phase_in = g_ph;
            else begin
               skip_in = g_tgt[16:0];
               skip_ph_in = g_ph;
               phase_in = tlshp_pkg::PH_SKIP;
            end
         end
         if (f_sni) begin
            if (nx + 18'd3 <= {1'b0, sec_ff}) phase_in = tlshp_pkg::PH_NTYPE;
            else begin
               f_eskip = 1'b1; es_dend = {1'b0, sec_ff};
            end
         end
         if (f_eskip) begin
            sec_in = es_dend[16:0];
            if (es_dend <= nx) f_next = 1'b1;
            else phase_in = tlshp_pkg::PH_EXT_SKIP;
         end
         if (f_next) begin
            if (nx + 18'd4 <= {1'b0, ext_in}) phase_in = tlshp_pkg::PH_ET_HI;
            else f_done = 1'b1;
         end
         if (f_done) begin
            e = tlshp_pkg::mk_event(tlshp_pkg::EV_HELLO_DONE, 16'd0, 16'd0, rt, 1'b0, 5'd0,
                                    tlshp_pkg::ERR_NONE, 1'b0, 2'd0);
            ev[n[0]] = e;
            n = n + 2'd1;
            phase_in = tlshp_pkg::PH_DONE;
         end
      end

      // Mark the last entry of this beat
      if (n == 2'd1) ev[0].last = 1'b1;
      if (n == 2'd2) ev[1].last = 1'b1;
   end

   assign push_n = accept ? n : 2'd0;
   assign ev0    = ev[0];
   assign ev1    = ev[1];

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tlshp_pkg::PH_IDLE;
         skip_ph_ff <= tlshp_pkg::PH_IDLE;
         pos_ff     <= '0;
         tot_ff     <= '0;
         rl_ff      <= '0;
         rv_ff      <= '0;
         rt_ff      <= '0;
         acc_ff     <= '0;
         sec_ff     <= '0;
         ext_ff     <= '0;
         skip_ff    <= '0;
         sl_ff      <= '0;
         ek_ff      <= '0;
         hf_ff      <= 1'b0;
         nf_ff      <= '0;
         nr_ff      <= '0;
         ns_ff      <= '0;
         max_ff     <= 8'd255;
      end else begin
         phase_ff   <= phase_in;
         skip_ph_ff <= skip_ph_in;
         pos_ff     <= pos_in;
         tot_ff     <= tot_in;
         rl_ff      <= rl_in;
         rv_ff      <= rv_in;
         rt_ff      <= rt_in;
         acc_ff     <= acc_in;
         sec_ff     <= sec_in;
         ext_ff     <= ext_in;
         skip_ff    <= skip_in;
         sl_ff      <= sl_in;
         ek_ff      <= ek_in;
         hf_ff      <= hf_in;
         nf_ff      <= nf_in;
         nr_ff      <= nr_in;
         ns_ff      <= ns_in;
         if (csr_we) max_ff <= csr_wdata;
      end
   end

   // A finished parse stays silent until the next first beat
   `TLSHP_ASSERT(a_done_silent, clock, reset,
      !(accept && !first_byte && phase_ff == tlshp_pkg::PH_DONE) || push_n == 2'd0)

endmodule

/* rtl/tlshp_queue.sv */
// Short result queue between front and back: up to two pushes and one
// pop per cycle. Depends on tlshp_pkg.
`include "assert_macros.svh"

module tlshp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_n,
   input  tlshp_pkg::event_type ev0,
   input  tlshp_pkg::event_type ev1,
   output logic                 space_ok,
   output logic                 out_valid,
   output tlshp_pkg::event_type out_data,
   input  logic                 pop
);

   localparam int DEPTH = tlshp_pkg::QUEUE_DEPTH;
   localparam int PW    = tlshp_pkg::QPTR_BITS;

   tlshp_pkg::event_type mem_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in, wp1;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          do_pop;

   assign do_pop    = pop && (cnt_ff != '0);
   assign wp1       = wp_ff + PW'(1);
   assign wp_in     = wp_ff + PW'(push_n);
   assign rp_in     = do_pop ? rp_ff + PW'(1) : rp_ff;
   assign cnt_in    = cnt_ff + (PW + 1)'(push_n) - (PW + 1)'(do_pop);
   assign space_ok  = (cnt_ff <= (PW + 1)'(DEPTH - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];

   // Write pushed entries
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wp_ff] <= ev0;
      if (push_n == 2'd2) mem_ff[wp1] <= ev1;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   `TLSHP_ASSERT(a_no_overflow, clock, reset,
      push_n == 2'd0 || cnt_ff <= (PW + 1)'(DEPTH - 2))
   `TLSHP_ASSERT(a_fill_bound, clock, reset, cnt_ff <= (PW + 1)'(DEPTH))

endmodule

/* rtl/tlshp_back.sv */
// Back end: pops result entries, applies counter bumps and holds the
// output beat register. Depends on tlshp_pkg.
`include "assert_macros.svh"

module tlshp_back #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  tlshp_pkg::event_type q_data,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [119:0]         rsp_tdata,
   output logic [3:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   localparam int CW = COUNTER_BITS;
   localparam logic [CW-1:0] CMAX = {CW{1'b1}};

   logic [CW-1:0] cnt_ff [4];
   logic [CW-1:0] cnt_in [4];
   logic [15:0]   shown_in [4];
   logic [15:0]   shown_ff [4];
   tlshp_pkg::event_type out_ff;
   logic          valid_ff, take;

   assign take  = q_valid && (!valid_ff || rsp_tready);
   assign q_pop = take;

   // Bump counters and clamp the shown copies
   always_comb begin
      logic [CW+15:0] wide;
      for (int k = 0; k < 4; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (take && q_data.bump_en && q_data.bump_idx == 2'(k) && cnt_ff[k] != CMAX)
            cnt_in[k] = cnt_ff[k] + CW'(1);
         wide = {16'b0, cnt_in[k]};
         shown_in[k] = (wide > (CW + 16)'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
      end else begin
         if (take) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) cnt_ff[k] <= cnt_in[k];
      end
   end

   // Load the output beat
   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= q_data;
         for (int k = 0; k < 4; k++) shown_ff[k] <= shown_in[k];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {7'd0, shown_ff[tlshp_pkg::CNT_WEAK_VERSION],
                        shown_ff[tlshp_pkg::CNT_WEAK_CIPHER],
                        shown_ff[tlshp_pkg::CNT_SERVER], shown_ff[tlshp_pkg::CNT_CLIENT],
                        out_ff.err, out_ff.code, out_ff.weak_flag, out_ff.rtype,
                        out_ff.len, out_ff.value};

   `TLSHP_ASSERT_NEXT(a_take_shows, clock, reset, take, rsp_tvalid)

endmodule

/* rtl/tls_hello_stream_parser_core.sv */
// Top level of the TLS hello stream parser: front parser, result queue
// and output back end. Depends on tlshp_pkg, tlshp_front, tlshp_queue, tlshp_back.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata byte+length, tuser first flag
//   rsp      out  rsp_tvalid/tready    tdata fields, tuser kind, tlast
//   csr      in   csr_we               csr_wdata max name bytes
//
// One payload beat per cycle while each beat gives at most one result and the
// result side is not stalled; two-result beats outpace the one-entry-per-cycle
// drain of the queue into the output register. A result goes through the queue
// and then the output register. Reset is synchronous and clears parse state,
// counters and queue. req_tready drops with fewer than two queue entries free.

module tls_hello_stream_parser_core #(
   parameter int COUNTER_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // data_byte[7:0], payload_length[23:8]
   input  logic [0:0]   req_tuser,   // first_byte[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value[15:0], length_value[31:16], record_content_type[39:32], is_weak[40],
   // name_code[45:41], error_code[48:46], client_hello_total[64:49],
   // server_hello_total[80:65], weak_cipher_total[96:81],
   // weak_version_total[112:97], zero[119:113]
   output logic [119:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // event_kind[3:0]
   output logic         rsp_tlast,   // last_of_run
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata    // max_name_bytes
);

   logic                 accept, space_ok, q_valid, q_pop;
   logic [1:0]           push_n;
   tlshp_pkg::event_type ev0, ev1, q_data;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && space_ok;

   tlshp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_tdata[7:0]),
      .first_byte     (req_tuser[0]),
      .payload_length (req_tdata[23:8]),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .push_n         (push_n),
      .ev0            (ev0),
      .ev1            (ev1)
   );

   tlshp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .ev0       (ev0),
      .ev1       (ev1),
      .space_ok  (space_ok),
      .out_valid (q_valid),
      .out_data  (q_data),
      .pop       (q_pop)
   );

   tlshp_back #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/tls_hello_stream_parser_core_test.sv */
// Self-checking testbench of the TLS hello stream parser core.
// Builds ClientHello, ServerHello and broken payloads, predicts the parse events
// on its own and checks every result beat; depends on tlshp_pkg and the core RTL.
module tls_hello_stream_parser_core_test;
   import tlshp_pkg::*;

   // One payload byte as it waits to be offered
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic [15:0] plen;
   } payload_beat_type;

   // One parse event as the core should report it
   typedef struct {
      event_kind_type kind;
      logic [15:0]    value;
      logic [15:0]    len;
      logic [7:0]     rtype;
      logic           weak_flag;
      logic [4:0]     code;
      logic [2:0]     err;
      logic [15:0]    tally [4];
      logic           last;
   } parse_event_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_wdata = 8'd0;

   payload_beat_type pending_bytes [$];
   parse_event_type  expected_events [$];
   parse_event_type  step_events [$];
   logic [7:0]       pl [$];

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_given = 0;
   int unsigned hold_left = 0;
   int unsigned error_count = 0;
   int unsigned checked_count = 0;
   int unsigned payload_count = 0;
   int unsigned quiet_cycles = 0;
   bit          req_took = 1'b0;

   // Parser state kept by the predictor
   int unsigned name_cap = 255;
   phase_type   phase = PH_IDLE;
   phase_type   resume_phase = PH_IDLE;
   int unsigned pos, ptotal, rec_len, acc, sec_end, ext_end, name_left;
   int unsigned rec_type, rec_ver, skip_target, suites_left, ext_code;
   int unsigned sni_host, sni_len, names_sent;
   int unsigned tally [4];

   logic [15:0] known_suites [28] = '{
      16'h1301, 16'h1302, 16'h1303, 16'h1304, 16'h1305,
      16'h009C, 16'h009D, 16'h002F, 16'h0035, 16'h003C, 16'h003D,
      16'hC02B, 16'hC02C, 16'hC02F, 16'hC030, 16'hC00A, 16'hC009, 16'hC013,
      16'hC014, 16'hCCA8, 16'hCCA9,
      16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h000A};

   tls_hello_stream_parser_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------- predictor ----------------
   function int unsigned version_index(int unsigned v);
      return (v >= 16'h0300 && v <= 16'h0304) ? v - 16'h0300 + 1 : 0;
   endfunction

   function int unsigned version_is_weak(int unsigned v);
      return (v >= 16'h0300 && v <= 16'h0302) ? 1 : 0;
   endfunction

   function int unsigned suite_index(int unsigned s);
      for (int k = 0; k < 28; k++)
         if (known_suites[k] == s) return k + 1;
      return 0;
   endfunction

   function int unsigned suite_is_weak(int unsigned s);
      return (s <= 16'h0005 || s == 16'h000A) ? 1 : 0;
   endfunction

   function void bump_tally(int idx);
      if (tally[idx] < 65535) tally[idx]++;
   endfunction

   function void add_event(event_kind_type kind, int unsigned val, int unsigned len,
                           int unsigned weak_bit, int unsigned code, logic [2:0] err);
      parse_event_type e;
      if (step_events.size() >= 3) return;
      e.kind = kind;
      e.value = val[15:0];
      e.len = len[15:0];
      e.rtype = rec_type[7:0];
      e.weak_flag = weak_bit[0];
      e.code = code[4:0];
      e.err = err;
      for (int k = 0; k < 4; k++) e.tally[k] = tally[k][15:0];
      e.last = 1'b0;
      step_events.push_back(e);
   endfunction

   function void stop_with(logic [2:0] err);
      add_event(EV_ERROR, 0, 0, 0, 0, err);
      phase = PH_DONE;
   endfunction

   function void jump_to(int unsigned target, phase_type ph);
      if (target <= pos + 1) begin
         phase = ph;
      end else begin
         skip_target = target;
         resume_phase = ph;
         phase = PH_SKIP;
      end
   endfunction

   function void client_finish();
      add_event(EV_HELLO_DONE, 0, 0, 0, 0, ERR_NONE);
      phase = PH_DONE;
   endfunction

   function void server_finish();
      bump_tally(CNT_SERVER);
      add_event(EV_HELLO_DONE, 0, 0, 0, 0, ERR_NONE);
      phase = PH_DONE;
   endfunction

   function void next_extension();
      if (pos + 5 <= ext_end) phase = PH_ET_HI;
      else client_finish();
   endfunction

   function void skip_extension(int unsigned dend);
      sec_end = dend;
      if (dend <= pos + 1) next_extension();
      else phase = PH_EXT_SKIP;
   endfunction

   function void next_name();
      if (pos + 4 <= sec_end) phase = PH_NTYPE;
      else skip_extension(sec_end);
   endfunction

   function void to_compression(int unsigned at);
      if (at + 1 > rec_len + 5) phase = PH_DONE;
      else jump_to(at, PH_COMPLEN);
   endfunction

   // Advance the parse by one payload byte
   function void parse_byte(int unsigned b);
      int unsigned p, nx, lim, v, w;
      p = pos;
      nx = p + 1;
      lim = rec_len + 5;
      v = acc | b;
      case (phase)
         PH_HDR: begin
            if (p == 0) rec_type = b;
            else if (p == 1 || p == 3) acc = b << 8;
            else if (p == 2) rec_ver = v;
            else begin
               rec_len = v;
               add_event(EV_REC_HEADER, rec_ver, rec_len, 0, version_index(rec_ver),
                         ERR_NONE);
               if (rec_type != REC_HANDSHAKE) stop_with(ERR_NOT_HANDSHAKE);
               else if (ptotal < 9) phase = PH_DONE;
               else phase = PH_HSTYPE;
            end
         end
         PH_HSTYPE: begin
            if (b == HS_CLIENT) begin
               if (lim > ptotal) stop_with(ERR_INCOMPLETE);
               else if (rec_len < 4) stop_with(ERR_HS_SHORT);
               else begin
                  w = version_is_weak(rec_ver);
                  if (w != 0) bump_tally(CNT_WEAK_VERSION);
                  add_event(EV_REC_VERSION, rec_ver, rec_len, w, version_index(rec_ver),
                            ERR_NONE);
                  if (rec_len < 6) phase = PH_DONE;
                  else jump_to(9, PH_CVER_HI);
               end
            end else if (b == HS_SERVER) begin
               if (ptotal < 47) stop_with(ERR_SERVER_SHORT);
               else jump_to(9, PH_SVER_HI);
            end else begin
               add_event(EV_OTHER_HS, b, 0, 0, 0, ERR_NONE);
               phase = PH_DONE;
            end
         end
         PH_CVER_HI, PH_CSLEN_HI, PH_SUITE_HI, PH_EXTL_HI, PH_ET_HI, PH_ES_HI,
         PH_SL_HI, PH_NL_HI, PH_SVER_HI, PH_SCS_HI: begin
            acc = b << 8;
            phase = phase_type'(phase + 1);
         end
         PH_CVER_LO: begin
            bump_tally(CNT_CLIENT);
            add_event(EV_CLIENT_VERSION, v, 0, 0, version_index(v), ERR_NONE);
            if (rec_len < 39) phase = PH_DONE;
            else jump_to(43, PH_CSID);
         end
         PH_CSID: begin
            if (nx + b + 2 > lim) phase = PH_DONE;
            else jump_to(nx + b, PH_CSLEN_HI);
         end
         PH_CSLEN_LO: begin
            if (nx + v > lim) phase = PH_DONE;
            else begin
               sec_end = nx + v;
               suites_left = v >> 1;
               if (suites_left == 0) to_compression(sec_end);
               else phase = PH_SUITE_HI;
            end
         end
         PH_SUITE_LO: begin
            w = suite_is_weak(v);
            if (w != 0) bump_tally(CNT_WEAK_CIPHER);
            add_event(EV_OFFERED_SUITE, v, 0, w, suite_index(v), ERR_NONE);
            suites_left--;
            if (suites_left == 0) to_compression(sec_end);
            else phase = PH_SUITE_HI;
         end
         PH_COMPLEN: begin
            if (nx + b + 2 > lim) phase = PH_DONE;
            else jump_to(nx + b, PH_EXTL_HI);
         end
         PH_EXTL_LO: begin
            if (nx + v > lim) phase = PH_DONE;
            else begin
               ext_end = nx + v;
               next_extension();
            end
         end
         PH_ET_LO: begin
            ext_code = v;
            phase = PH_ES_HI;
         end
         PH_ES_LO: begin
            if (nx + v > ext_end) client_finish();
            else if (ext_code != 0) begin
               add_event(EV_EXTENSION, ext_code, v, 0, 0, ERR_NONE);
               skip_extension(nx + v);
            end else if (nx + 2 > ext_end) client_finish();
            else if (v < 2) skip_extension(nx + v);
            else begin
               sec_end = nx + v;
               phase = PH_SL_HI;
            end
         end
         PH_EXT_SKIP: if (nx >= sec_end) next_extension();
         PH_SL_LO: next_name();
         PH_NTYPE: begin
            sni_host = (b == 0) ? 1 : 0;
            phase = PH_NL_HI;
         end
         PH_NL_LO: begin
            if (nx + v > sec_end) skip_extension(sec_end);
            else begin
               sni_len = v;
               name_left = v;
               names_sent = 0;
               if (v == 0) next_name();
               else phase = PH_NAME;
            end
         end
         PH_NAME: begin
            if (sni_host != 0 && names_sent < name_cap) begin
               add_event(EV_SNI_BYTE, b, sni_len, 0, 0, ERR_NONE);
               names_sent++;
            end
            name_left--;
            if (name_left == 0) next_name();
         end
         PH_SVER_LO: begin
            w = version_is_weak(v);
            if (w != 0) bump_tally(CNT_WEAK_VERSION);
            add_event(EV_SERVER_VERSION, v, 0, w, version_index(v), ERR_NONE);
            jump_to(43, PH_SSID);
         end
         PH_SSID: begin
            if (nx + b + 2 <= ptotal) jump_to(nx + b, PH_SCS_HI);
            else if (nx + b + 1 <= ptotal) jump_to(nx + b, PH_SCOMP);
            else server_finish();
         end
         PH_SCS_LO: begin
            w = suite_is_weak(v);
            if (w != 0) bump_tally(CNT_WEAK_CIPHER);
            add_event(EV_SELECTED_SUITE, v, 0, w, suite_index(v), ERR_NONE);
            if (nx + 1 <= ptotal) phase = PH_SCOMP;
            else server_finish();
         end
         PH_SCOMP: begin
            add_event(EV_COMPRESSION, b, 0, 0, 0, ERR_NONE);
            server_finish();
         end
         PH_SKIP: if (nx >= skip_target) phase = resume_phase;
         default: phase = PH_DONE;
      endcase
   endfunction

   // Work out the events of one accepted byte and queue them
   function void predict_beat(payload_beat_type bt);
      bit active;
      step_events.delete();
      active = 1'b1;
      if (bt.first) begin
         ptotal = bt.plen;
         pos = 0;
         rec_len = 0;
         rec_type = 0;
         rec_ver = 0;
         if (ptotal < 5) begin
            stop_with(ERR_PAYLOAD_SHORT);
            active = 1'b0;
         end else begin
            phase = PH_HDR;
         end
      end
      if (active && phase != PH_IDLE && phase != PH_DONE) begin
         if (pos >= ptotal) phase = PH_DONE;
         else begin
            parse_byte(bt.data);
            if (pos < 65535) pos++;
         end
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[k]) expected_events.push_back(step_events[k]);
   endfunction

   // ---------------- driver, receiver, monitor ----------------
   // Predict each accepted request beat
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_beat(pending_bytes.pop_front());
         req_took = 1'b1;
      end
   end

   // Offer the next beat, hold an unaccepted one, idle at random
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         req_tvalid <= 1'b1;
      end else if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
         req_tvalid <= 1'b1;
         req_tdata <= {pending_bytes[0].plen, pending_bytes[0].data};
         req_tuser <= pending_bytes[0].first;
      end else begin
         req_tvalid <= 1'b0;
      end
      req_took = 1'b0;
   end

   // Stall the result side at random, or hold off for a long stretch on request
   always @(negedge clock) begin
      if (hold_given != hold_asked) begin
         hold_given = hold_asked;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
      error_count++;
   endtask

   // Check each result beat against the oldest expected event
   always @(posedge clock) begin
      parse_event_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected beat kind", rsp_tuser, 0);
         end else begin
            e = expected_events.pop_front();
            checked_count++;
            if (rsp_tuser != e.kind) report_mismatch("kind", rsp_tuser, e.kind);
            if (rsp_tdata[15:0] != e.value) report_mismatch("value", rsp_tdata[15:0], e.value);
            if (rsp_tdata[31:16] != e.len) report_mismatch("length", rsp_tdata[31:16], e.len);
            if (rsp_tdata[39:32] != e.rtype)
               report_mismatch("content type", rsp_tdata[39:32], e.rtype);
            if (rsp_tdata[40] != e.weak_flag)
               report_mismatch("weak", rsp_tdata[40], e.weak_flag);
            if (rsp_tdata[45:41] != e.code) report_mismatch("name code", rsp_tdata[45:41], e.code);
            if (rsp_tdata[48:46] != e.err) report_mismatch("error", rsp_tdata[48:46], e.err);
            for (int k = 0; k < 4; k++)
               if (rsp_tdata[49 + 16 * k +: 16] != e.tally[k])
                  report_mismatch($sformatf("counter %0d", k), rsp_tdata[49 + 16 * k +: 16],
                                  e.tally[k]);
            if (rsp_tdata[119:113] != 0) report_mismatch("pad", rsp_tdata[119:113], 0);
            if (rsp_tlast != e.last) report_mismatch("last", rsp_tlast, e.last);
         end
      end
   end

   // End the run when no beat moves for too long while work is open
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_bytes.size() == 0 && expected_events.size() == 0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= 3000) begin
            $display("watchdog expired with %0d bytes and %0d events open",
                     pending_bytes.size(), expected_events.size());
            $display("tls_hello_stream_parser_core test failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   function void put16(int unsigned v);
      pl.push_back(v[15:8]);
      pl.push_back(v[7:0]);
   endfunction

   function void patch16(int idx, int unsigned v);
      pl[idx] = v[15:8];
      pl[idx + 1] = v[7:0];
   endfunction

   function int unsigned pick_version();
      return ($urandom_range(0, 4) != 0) ? 16'h0300 + $urandom_range(0, 4)
                                         : $urandom_range(0, 65535);
   endfunction

   function int unsigned pick_suite();
      return ($urandom_range(0, 2) != 0) ? known_suites[$urandom_range(0, 27)]
                                         : $urandom_range(0, 65535);
   endfunction

   // Queue the built payload; declare its length, garbage in later length fields
   function void queue_payload(int unsigned declared);
      payload_beat_type bt;
      foreach (pl[k]) begin
         bt.data = pl[k];
         bt.first = (k == 0);
         bt.plen = (k == 0) ? declared[15:0] : 16'($urandom_range(0, 65535));
         pending_bytes.push_back(bt);
      end
      payload_count++;
   endfunction

   function void queue_directed(int unsigned declared, logic [7:0] bytes [$]);
      pl = bytes;
      queue_payload(declared);
   endfunction

   function void build_client();
      int at_ext, at_sni, at_list, n;
      pl.delete();
      pl.push_back(REC_HANDSHAKE);
      put16(pick_version());
      put16(0);
      pl.push_back(HS_CLIENT);
      pl.push_back(0);
      put16(0);
      put16(pick_version());
      repeat (32) pl.push_back($urandom_range(0, 255));
      n = $urandom_range(0, 4);
      pl.push_back(n);
      repeat (n) pl.push_back($urandom_range(0, 255));
      n = $urandom_range(0, 4);
      put16(2 * n + (($urandom_range(0, 5) == 0) ? 1 : 0));
      repeat (n) put16(pick_suite());
      if (pl[pl.size() - 1] == 0 && pl.size() % 2 == 0) pl.push_back($urandom_range(0, 255));
      pl.push_back(1);
      pl.push_back(0);
      at_ext = pl.size();
      put16(0);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 1) == 0) begin
            put16(0);
            at_sni = pl.size();
            put16(0);
            at_list = pl.size();
            put16(0);
            repeat ($urandom_range(1, 2)) begin
               pl.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : 0);
               n = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
               put16(n);
               repeat (n) pl.push_back($urandom_range(0, 255));
            end
            patch16(at_list, pl.size() - at_list - 2);
            patch16(at_sni, pl.size() - at_sni - 2);
         end else begin
            put16($urandom_range(1, 65535));
            n = $urandom_range(0, 4);
            put16(n);
            repeat (n) pl.push_back($urandom_range(0, 255));
         end
      end
      patch16(at_ext, pl.size() - at_ext - 2);
      patch16(3, pl.size() - 5);
      patch16(7, pl.size() - 9);
   endfunction

   function void build_server();
      int n;
      pl.delete();
      pl.push_back(REC_HANDSHAKE);
      put16(pick_version());
      put16(0);
      pl.push_back(HS_SERVER);
      pl.push_back(0);
      put16(0);
      put16(pick_version());
      repeat (32) pl.push_back($urandom_range(0, 255));
      n = $urandom_range(0, 4);
      pl.push_back(n);
      repeat (n) pl.push_back($urandom_range(0, 255));
      put16(pick_suite());
      pl.push_back($urandom_range(0, 255));
      patch16(3, pl.size() - 5);
      patch16(7, pl.size() - 9);
   endfunction

   // Mostly well-formed hellos, then corrupted, cut and noise payloads
   function void queue_random_payload();
      int unsigned kind, declared;
      kind = $urandom_range(0, 99);
      if (kind < 45) build_client();
      else if (kind < 75) build_server();
      else begin
         pl.delete();
         repeat ($urandom_range(1, 12)) pl.push_back($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 0) pl[0] = REC_HANDSHAKE;
      end
      if (kind < 75 && $urandom_range(0, 3) == 0)
         pl[$urandom_range(0, pl.size() - 1)] = $urandom_range(0, 255);
      if (kind < 75 && $urandom_range(0, 6) == 0)
         repeat ($urandom_range(1, 20)) if (pl.size() > 1) void'(pl.pop_back());
      declared = pl.size();
      case ($urandom_range(0, 9))
         0: declared = $urandom_range(0, 65535);
         1: declared = pl.size() + $urandom_range(1, 30);
         2: declared = (pl.size() > 2) ? pl.size() - $urandom_range(1, 2) : 0;
         3: declared = ($urandom_range(0, 1) == 0) ? 0 : 65535;
         default: ;
      endcase
      queue_payload(declared);
   endfunction

   task wait_idle();
      while (pending_bytes.size() > 0 || expected_events.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_name_cap(int unsigned v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v[7:0];
      name_cap = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task run_phase(int unsigned gap, int unsigned stall, int unsigned cap, bit hold);
      int unsigned target;
      wait_idle();
      write_name_cap(cap);
      idle_pct = gap;
      stall_pct = stall;
      if (hold) hold_asked++;
      target = pending_bytes.size() + 50;
      while (pending_bytes.size() < target) queue_random_payload();
   endtask

   initial begin
      for (int k = 0; k < 4; k++) tally[k] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: stray bytes, short payload, foreign record, header only,
      // other handshake type, oversize record, short record, short server hello
      queue_directed(16'hFFFF, '{8'hFF, 8'h00, 8'h16});
      pending_bytes[0].first = 1'b0;
      pending_bytes[1].first = 1'b0;
      pending_bytes[2].first = 1'b0;
      queue_directed(0, '{8'hFF});
      queue_directed(3, '{8'h00});
      queue_directed(5, '{8'h17, 8'h03, 8'h03, 8'h00, 8'h00});
      queue_directed(6, '{REC_HANDSHAKE, 8'h03, 8'h01, 8'hFF, 8'hFF, 8'h01});
      queue_directed(9, '{REC_HANDSHAKE, 8'h03, 8'h04, 8'h00, 8'h04, 8'h08});
      queue_directed(9, '{REC_HANDSHAKE, 8'h03, 8'h03, 8'h00, 8'h28, HS_CLIENT});
      queue_directed(9, '{REC_HANDSHAKE, 8'h03, 8'h00, 8'h00, 8'h02, HS_CLIENT});
      queue_directed(30, '{REC_HANDSHAKE, 8'h03, 8'h02, 8'h00, 8'h28, HS_SERVER});

      // Random phases through the idling mixes and name caps
      run_phase(0, 0, 255, 1'b0);
      run_phase(53, 0, 1, 1'b0);
      run_phase(0, 53, $urandom_range(2, 254), 1'b0);
      run_phase(0, 0, 3, 1'b1);
      run_phase(27, 27, $urandom_range(1, 8), 1'b0);
      wait_idle();
      repeat (20) @(posedge clock);

      $display("covered %0d payloads and %0d result beats with name caps 1 to 255",
               payload_count, checked_count);
      if (error_count == 0) begin
         $display("tls_hello_stream_parser_core test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tls_hello_stream_parser_core test failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/tlshp_pkg.sv
rtl/tlshp_front.sv
rtl/tlshp_queue.sv
rtl/tlshp_back.sv
rtl/tls_hello_stream_parser_core.sv
tb/tls_hello_stream_parser_core_test.sv
